[rtl/core/ges_pkg.sv]
`default_nettype none
package ges_pkg;

    localparam int DATA_W   = 32;
    localparam int ACC_W    = 40;
    localparam int THR_W    = 16;
    localparam int PADDR_W  = 3;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd1;

    // register index is taken from paddr[2]
    localparam logic REG_SINGULAR_THRESHOLD = 1'b0;

    typedef enum logic {
        ALU_MUL = 1'b0,
        ALU_DIV = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

endpackage
`default_nettype wire

[rtl/core/ges_alu.sv]
`default_nettype none
module ges_alu (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire ges_pkg::alu_req_t                   req,
    input  wire logic signed [ges_pkg::ACC_W-1:0]    a,
    input  wire logic signed [ges_pkg::ACC_W-1:0]    b,
    output logic                                     done,
    output logic signed [ges_pkg::ACC_W-1:0]         result
);
    import ges_pkg::*;

    localparam int HALF   = ACC_W / 2;
    localparam int PROD_W = 2 * ACC_W;
    localparam int DIV_W  = ACC_W + 16;
    localparam int MAG_W  = PROD_W - 16;
    localparam int CNT_W  = $clog2(DIV_W);

    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32'h8000);
    localparam logic [MAG_W-1:0]  MAG_LIM    = MAG_W'(1) << (ACC_W - 1);

    typedef enum logic [4:0] {
        A_IDLE  = 5'b00001,
        A_MUL   = 5'b00010,
        A_DPREP = 5'b00100,
        A_DIV   = 5'b01000,
        A_FIN   = 5'b10000
    } alu_state_t;

    alu_state_t               state_reg, state_next;
    alu_op_t                  op_reg, op_next;
    logic                     neg_reg, neg_next;
    logic [ACC_W-1:0]         ua_reg, ua_next;
    logic [ACC_W-1:0]         ub_reg, ub_next;
    logic [PROD_W-1:0]        acc_reg, acc_next;
    logic [ACC_W-1:0]         rem_reg, rem_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     done_reg, done_next;
    logic signed [ACC_W-1:0]  result_reg, result_next;

    logic [HALF-1:0]          pa, pb;
    logic [ACC_W-1:0]         prod;
    logic [1:0]               sh;
    logic [ACC_W:0]           rem_sh, diff;
    logic [MAG_W-1:0]         m, mm;

    function automatic logic [ACC_W-1:0] mag(input logic signed [ACC_W-1:0] v);
        return v[ACC_W-1] ? (~v + 1'b1) : v;
    endfunction

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        neg_next    = neg_reg;
        ua_next     = ua_reg;
        ub_next     = ub_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        pa     = cnt_reg[1] ? ua_reg[ACC_W-1:HALF] : ua_reg[HALF-1:0];
        pb     = cnt_reg[0] ? ub_reg[ACC_W-1:HALF] : ub_reg[HALF-1:0];
        prod   = ACC_W'(pa) * ACC_W'(pb);
        sh     = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
        rem_sh = {rem_reg, acc_reg[DIV_W-1]};
        diff   = rem_sh - {1'b0, ub_reg};
        m      = (op_reg == ALU_MUL) ? acc_reg[PROD_W-1:16] : MAG_W'(acc_reg[DIV_W-1:0]);
        mm     = m;

        case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    ua_next  = mag(a);
                    ub_next  = mag(b);
                    neg_next = a[ACC_W-1] ^ b[ACC_W-1];
                    op_next  = req.op;
                    cnt_next = '0;
                    if (req.op == ALU_MUL)
                    begin
                        // rounding constant preloaded so no add at the end
                        acc_next   = ROUND_HALF;
                        state_next = A_MUL;
                    end
                    else
                    begin
                        state_next = A_DPREP;
                    end
                end
            end
            A_MUL:
            begin
                acc_next = acc_reg + (PROD_W'(prod) << (HALF * sh));
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[1:0] == 2'd3)
                begin
                    state_next = A_FIN;
                end
            end
            A_DPREP:
            begin
                acc_next   = PROD_W'({ua_reg, 16'b0}) + PROD_W'(ub_reg >> 1);
                rem_next   = '0;
                state_next = A_DIV;
            end
            A_DIV:
            begin
                // restoring division, one quotient bit per cycle
                rem_next = diff[ACC_W] ? rem_sh[ACC_W-1:0] : diff[ACC_W-1:0];
                acc_next[DIV_W-1:0] = {acc_reg[DIV_W-2:0], ~diff[ACC_W]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_W - 1))
                begin
                    state_next = A_FIN;
                end
            end
            A_FIN:
            begin
                if (neg_reg)
                begin
                    mm          = (m > MAG_LIM) ? MAG_LIM : m;
                    result_next = -$signed(ACC_W'(mm));
                end
                else
                begin
                    mm          = (m > MAG_LIM - 1'b1) ? (MAG_LIM - 1'b1) : m;
                    result_next = $signed(ACC_W'(mm));
                end
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        neg_reg    <= neg_next;
        ua_reg     <= ua_next;
        ub_reg     <= ub_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

[rtl/core/gaussian_elimination_solver_core.sv]
`default_nettype none
// Solves an N by N linear system (N up to MAX_UNKNOWNS) by Gaussian elimination
// with partial pivoting. Matrix elements are loaded one per cycle as signed
// Q16.16; the transaction marked last_element starts the solve, and no new
// element is taken until the last result has gone out. A solve first copies
// the loaded matrix into a 40-bit working memory, then walks pivot search, row
// swap, elimination and back substitution through that memory. Each quotient
// comes from the bit-serial divider and each product from the multiplier of
// the same ALU, and the divider dominates the solve time. The answer is one
// result per unknown, or a single singular-status result when a pivot magnitude
// is zero or below singular_threshold.
module gaussian_elimination_solver_core #(
    parameter int MAX_UNKNOWNS = 3
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [ges_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    input  wire logic                             item_valid,
    output logic                                  item_ready,
    input  wire logic [1:0]                       row_index,
    input  wire logic [1:0]                       col_index,
    input  wire logic signed [ges_pkg::DATA_W-1:0] coefficient_value,
    input  wire logic [1:0]                       system_size,
    input  wire logic                             last_element,
    output logic                                  result_valid,
    input  wire logic                             result_ready,
    output logic signed [ges_pkg::DATA_W-1:0]     solution_value,
    output logic [1:0]                            variable_index,
    output logic                                  status,
    output logic                                  last_result
);
    import ges_pkg::*;

    localparam int IW    = $clog2(MAX_UNKNOWNS + 1);
    localparam int DEPTH = MAX_UNKNOWNS * (MAX_UNKNOWNS + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_UNKNOWNS + 1);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);

    typedef enum logic [27:0] {
        S_IDLE     = 28'b1 << 0,
        S_CP_RD    = 28'b1 << 1,
        S_CP_WR    = 28'b1 << 2,
        S_PV_RD    = 28'b1 << 3,
        S_PV_CMP   = 28'b1 << 4,
        S_SW_RA    = 28'b1 << 5,
        S_SW_RB    = 28'b1 << 6,
        S_SW_WA    = 28'b1 << 7,
        S_SW_WB    = 28'b1 << 8,
        S_CHK      = 28'b1 << 9,
        S_EL_RDF   = 28'b1 << 10,
        S_EL_DIVS  = 28'b1 << 11,
        S_EL_DIVW  = 28'b1 << 12,
        S_EL_RDA   = 28'b1 << 13,
        S_EL_MULS  = 28'b1 << 14,
        S_EL_MULW  = 28'b1 << 15,
        S_EL_WR    = 28'b1 << 16,
        S_BS_RDS   = 28'b1 << 17,
        S_BS_S     = 28'b1 << 18,
        S_BS_LOOP  = 28'b1 << 19,
        S_BS_A     = 28'b1 << 20,
        S_BS_MULS  = 28'b1 << 21,
        S_BS_MULW  = 28'b1 << 22,
        S_BS_DIVS  = 28'b1 << 23,
        S_BS_DIVW  = 28'b1 << 24,
        S_OUT_RD   = 28'b1 << 25,
        S_OUT_LD   = 28'b1 << 26,
        S_OUT_WAIT = 28'b1 << 27
    } state_t;

    state_t                   state_reg, state_next;
    logic [THR_W-1:0]         thr_reg;
    logic [IW-1:0]            n_reg, n_next;
    logic [IW-1:0]            i_reg, i_next;
    logic [IW-1:0]            k_reg, k_next;
    logic [IW-1:0]            j_reg, j_next;
    logic [IW-1:0]            best_reg, best_next;
    logic [ACC_W-1:0]         bestmag_reg, bestmag_next;
    logic signed [ACC_W-1:0]  piv_reg, piv_next;
    logic signed [ACC_W-1:0]  a_reg, a_next;
    logic signed [ACC_W-1:0]  f_reg, f_next;
    logic signed [ACC_W-1:0]  s_reg, s_next;
    logic [AW-1:0]            cp_reg, cp_next;
    logic                     rv_reg, rv_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    logic [1:0]               vidx_reg, vidx_next;
    logic                     status_reg, status_next;
    logic                     last_reg, last_next;

    // loaded matrix as written, and the working copy
    logic signed [DATA_W-1:0] lmem [DEPTH];
    logic signed [ACC_W-1:0]  wmem [DEPTH];
    logic signed [DATA_W-1:0] lq_reg;
    logic signed [ACC_W-1:0]  wq_reg;

    logic                     item_fire, cfg_write;
    logic                     lwr_en;
    logic [AW-1:0]            laddr;
    logic                     wwr_en;
    logic [AW-1:0]            wwr_addr, wrd_addr;
    logic signed [ACC_W-1:0]  wwr_data;
    logic [1:0]               size_nz;
    logic [IW-1:0]            n_load;
    logic [ACC_W-1:0]         qmag;
    logic                     upd;

    alu_req_t                 alu_req;
    logic signed [ACC_W-1:0]  alu_a, alu_b, alu_res;
    logic                     alu_done;

    function automatic logic [AW-1:0] maddr(input logic [IW-1:0] r, input logic [IW-1:0] c);
        return AW'(r) * ROW_STRIDE + AW'(c);
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_sub(
        input logic signed [ACC_W-1:0] x,
        input logic signed [ACC_W-1:0] y
    );
        logic [ACC_W:0] d;
        d = {x[ACC_W-1], x} - {y[ACC_W-1], y};
        if (d[ACC_W] != d[ACC_W-1])
        begin
            return d[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return d[ACC_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
        if (v[ACC_W-1:DATA_W-1] != {(ACC_W-DATA_W+1){v[ACC_W-1]}})
        begin
            return v[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return v[DATA_W-1:0];
    endfunction

    ges_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (alu_a),
        .b      (alu_b),
        .done   (alu_done),
        .result (alu_res)
    );

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_SINGULAR_THRESHOLD);
    assign prdata    = (paddr[2] == REG_SINGULAR_THRESHOLD) ? 32'(thr_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            thr_reg <= pwdata[THR_W-1:0];
        end
    end

    // element load
    assign item_ready = (state_reg == S_IDLE);
    assign item_fire  = item_valid && item_ready;
    assign size_nz    = (system_size == 2'd0) ? 2'd1 : system_size;
    assign n_load     = (32'(size_nz) > MAX_UNKNOWNS) ? IW'(MAX_UNKNOWNS) : IW'(size_nz);
    assign laddr      = maddr(IW'(row_index), IW'(col_index));
    assign lwr_en     = item_fire && (32'(row_index) < MAX_UNKNOWNS)
                        && (32'(col_index) <= MAX_UNKNOWNS);

    always_ff @(posedge clk)
    begin
        if (lwr_en)
        begin
            lmem[laddr] <= coefficient_value;
        end
        lq_reg <= lmem[cp_reg];
    end

    // working memory; a read in the cycle an entry is written returns its old value
    always_ff @(posedge clk)
    begin
        if (wwr_en)
        begin
            wmem[wwr_addr] <= wwr_data;
        end
        wq_reg <= wmem[wrd_addr];
    end

    assign qmag = wq_reg[ACC_W-1] ? (~wq_reg + 1'b1) : wq_reg;
    assign upd  = (k_reg == i_reg) || (qmag > bestmag_reg);

    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        i_next       = i_reg;
        k_next       = k_reg;
        j_next       = j_reg;
        best_next    = best_reg;
        bestmag_next = bestmag_reg;
        piv_next     = piv_reg;
        a_next       = a_reg;
        f_next       = f_reg;
        s_next       = s_reg;
        cp_next      = cp_reg;
        rv_next      = rv_reg;
        value_next   = value_reg;
        vidx_next    = vidx_reg;
        status_next  = status_reg;
        last_next    = last_reg;
        wwr_en       = 1'b0;
        wwr_addr     = maddr(i_reg, j_reg);
        wwr_data     = wq_reg;
        wrd_addr     = maddr(i_reg, j_reg);
        alu_req      = '{start: 1'b0, op: ALU_MUL};
        alu_a        = a_reg;
        alu_b        = wq_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (item_fire)
                begin
                    n_next = n_load;
                    if (last_element)
                    begin
                        cp_next    = '0;
                        state_next = S_CP_RD;
                    end
                end
            end
            S_CP_RD:
            begin
                state_next = S_CP_WR;
            end
            S_CP_WR:
            begin
                wwr_en   = 1'b1;
                wwr_addr = cp_reg;
                wwr_data = {{(ACC_W-DATA_W){lq_reg[DATA_W-1]}}, lq_reg};
                if (cp_reg == LAST_ADDR)
                begin
                    i_next     = '0;
                    k_next     = '0;
                    state_next = S_PV_RD;
                end
                else
                begin
                    cp_next    = cp_reg + 1'b1;
                    state_next = S_CP_RD;
                end
            end
            S_PV_RD:
            begin
                wrd_addr   = maddr(k_reg, i_reg);
                state_next = S_PV_CMP;
            end
            S_PV_CMP:
            begin
                // ties keep the upper row
                if (upd)
                begin
                    best_next    = k_reg;
                    bestmag_next = qmag;
                    piv_next     = wq_reg;
                end
                if (k_reg == n_reg - 1'b1)
                begin
                    j_next     = i_reg;
                    state_next = ((upd ? k_reg : best_reg) != i_reg) ? S_SW_RA : S_CHK;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_PV_RD;
                end
            end
            S_SW_RA:
            begin
                wrd_addr   = maddr(i_reg, j_reg);
                state_next = S_SW_RB;
            end
            S_SW_RB:
            begin
                a_next     = wq_reg;
                wrd_addr   = maddr(best_reg, j_reg);
                state_next = S_SW_WA;
            end
            S_SW_WA:
            begin
                wwr_en     = 1'b1;
                wwr_addr   = maddr(i_reg, j_reg);
                wwr_data   = wq_reg;
                state_next = S_SW_WB;
            end
            S_SW_WB:
            begin
                wwr_en   = 1'b1;
                wwr_addr = maddr(best_reg, j_reg);
                wwr_data = a_reg;
                if (j_reg == n_reg)
                begin
                    state_next = S_CHK;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_SW_RA;
                end
            end
            S_CHK:
            begin
                if ((piv_reg == '0) || (bestmag_reg < ACC_W'(thr_reg)))
                begin
                    rv_next     = 1'b1;
                    value_next  = '0;
                    vidx_next   = '0;
                    status_next = 1'b1;
                    last_next   = 1'b1;
                    state_next  = S_OUT_WAIT;
                end
                else if (i_reg == n_reg - 1'b1)
                begin
                    state_next = S_BS_RDS;
                end
                else
                begin
                    k_next     = i_reg + 1'b1;
                    state_next = S_EL_RDF;
                end
            end
            S_EL_RDF:
            begin
                wrd_addr   = maddr(k_reg, i_reg);
                state_next = S_EL_DIVS;
            end
            S_EL_DIVS:
            begin
                alu_req    = '{start: 1'b1, op: ALU_DIV};
                alu_a      = wq_reg;
                alu_b      = piv_reg;
                state_next = S_EL_DIVW;
            end
            S_EL_DIVW:
            begin
                if (alu_done)
                begin
                    f_next     = alu_res;
                    j_next     = i_reg;
                    state_next = S_EL_RDA;
                end
            end
            S_EL_RDA:
            begin
                wrd_addr   = maddr(i_reg, j_reg);
                state_next = S_EL_MULS;
            end
            S_EL_MULS:
            begin
                alu_req    = '{start: 1'b1, op: ALU_MUL};
                alu_a      = f_reg;
                alu_b      = wq_reg;
                state_next = S_EL_MULW;
            end
            S_EL_MULW:
            begin
                wrd_addr = maddr(k_reg, j_reg);
                if (alu_done)
                begin
                    a_next     = alu_res;
                    state_next = S_EL_WR;
                end
            end
            S_EL_WR:
            begin
                wwr_en   = 1'b1;
                wwr_addr = maddr(k_reg, j_reg);
                wwr_data = sat_sub(wq_reg, a_reg);
                if (j_reg != n_reg)
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_EL_RDA;
                end
                else if (k_reg != n_reg - 1'b1)
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_EL_RDF;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    k_next     = i_reg + 1'b1;
                    state_next = S_PV_RD;
                end
            end
            S_BS_RDS:
            begin
                wrd_addr   = maddr(i_reg, n_reg);
                state_next = S_BS_S;
            end
            S_BS_S:
            begin
                s_next     = wq_reg;
                j_next     = i_reg + 1'b1;
                state_next = S_BS_LOOP;
            end
            S_BS_LOOP:
            begin
                if (j_reg < n_reg)
                begin
                    wrd_addr   = maddr(i_reg, j_reg);
                    state_next = S_BS_A;
                end
                else
                begin
                    wrd_addr   = maddr(i_reg, i_reg);
                    state_next = S_BS_DIVS;
                end
            end
            S_BS_A:
            begin
                // solved unknowns live in the constant column
                a_next     = wq_reg;
                wrd_addr   = maddr(j_reg, n_reg);
                state_next = S_BS_MULS;
            end
            S_BS_MULS:
            begin
                alu_req    = '{start: 1'b1, op: ALU_MUL};
                alu_a      = a_reg;
                alu_b      = wq_reg;
                state_next = S_BS_MULW;
            end
            S_BS_MULW:
            begin
                if (alu_done)
                begin
                    s_next     = sat_sub(s_reg, alu_res);
                    j_next     = j_reg + 1'b1;
                    state_next = S_BS_LOOP;
                end
            end
            S_BS_DIVS:
            begin
                alu_req    = '{start: 1'b1, op: ALU_DIV};
                alu_a      = s_reg;
                alu_b      = wq_reg;
                state_next = S_BS_DIVW;
            end
            S_BS_DIVW:
            begin
                if (alu_done)
                begin
                    wwr_en   = 1'b1;
                    wwr_addr = maddr(i_reg, n_reg);
                    wwr_data = alu_res;
                    if (i_reg == '0)
                    begin
                        state_next = S_OUT_RD;
                    end
                    else
                    begin
                        i_next     = i_reg - 1'b1;
                        state_next = S_BS_RDS;
                    end
                end
            end
            S_OUT_RD:
            begin
                wrd_addr   = maddr(i_reg, n_reg);
                state_next = S_OUT_LD;
            end
            S_OUT_LD:
            begin
                rv_next     = 1'b1;
                value_next  = sat_out(wq_reg);
                vidx_next   = 2'(i_reg);
                status_next = 1'b0;
                last_next   = (i_reg == n_reg - 1'b1);
                state_next  = S_OUT_WAIT;
            end
            S_OUT_WAIT:
            begin
                if (result_ready)
                begin
                    rv_next = 1'b0;
                    if (last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= IW'(1);
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg       <= i_next;
        k_reg       <= k_next;
        j_reg       <= j_next;
        best_reg    <= best_next;
        bestmag_reg <= bestmag_next;
        piv_reg     <= piv_next;
        a_reg       <= a_next;
        f_reg       <= f_next;
        s_reg       <= s_next;
        cp_reg      <= cp_next;
        value_reg   <= value_next;
        vidx_reg    <= vidx_next;
        status_reg  <= status_next;
        last_reg    <= last_next;
    end

    assign result_valid   = rv_reg;
    assign solution_value = value_reg;
    assign variable_index = vidx_reg;
    assign status         = status_reg;
    assign last_result    = last_reg;

endmodule
`default_nettype wire
